// File: design/bsc_pkg.sv
// Shared constants and helpers for the barometric compensation block.
// No dependencies; imported by bsc_div and the top level.
`default_nettype none
package bsc_pkg;
  localparam int unsigned DIV_W = 32;

  localparam logic [31:0] T_OFFSET  = 32'd4000;
  localparam logic [31:0] P_K1      = 32'd3038;
  localparam logic [31:0] P_K2      = 32'd7357;
  localparam logic [31:0] P_K3      = 32'd3791;
  localparam logic [15:0] P_SCALE   = 16'd50000;
  localparam logic [31:0] B4_OFFSET = 32'd32768;
  localparam logic [31:0] T_ROUND   = 32'd8;

  localparam logic [2:0] REG_AC123 = 3'd0;
  localparam logic [2:0] REG_AC456 = 3'd1;
  localparam logic [2:0] REG_B12   = 3'd2;
  localparam logic [2:0] REG_MCMD  = 3'd3;
  localparam logic [2:0] REG_OSS   = 3'd4;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = 32'($signed(v) >>> s);
  endfunction
endpackage
`default_nettype wire

// File: design/bsc_div.sv
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Depends on bsc_pkg; a sideband word travels alongside each beat.
`default_nettype none
module bsc_div import bsc_pkg::*; #(
  parameter int unsigned SW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [DIV_W-1:0]  num,
  input  wire logic [DIV_W-1:0]  den,
  input  wire logic [SW-1:0]     side_in,
  output logic                   out_vld,
  output logic [DIV_W-1:0]       quo,
  output logic [SW-1:0]          side_out
);
  logic [DIV_W-1:0] rem  [DIV_W];
  logic [DIV_W-1:0] qn   [DIV_W];
  logic [DIV_W-1:0] dv   [DIV_W];
  logic [SW-1:0]    sd   [DIV_W];
  logic             vld  [DIV_W];

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic [DIV_W-1:0] rem_p, qn_p, dv_p;
    logic [SW-1:0]    sd_p;
    logic             vld_p;
    logic [DIV_W:0]   trial;
    logic             take;
    if (i == 0) begin : g_first
      assign rem_p = '0;
      assign qn_p  = num;
      assign dv_p  = den;
      assign sd_p  = side_in;
      assign vld_p = in_vld;
    end else begin : g_next
      assign rem_p = rem[i-1];
      assign qn_p  = qn[i-1];
      assign dv_p  = dv[i-1];
      assign sd_p  = sd[i-1];
      assign vld_p = vld[i-1];
    end
    assign trial = {rem_p, qn_p[DIV_W-1]};
    assign take  = trial >= {1'b0, dv_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? DIV_W'(trial - {1'b0, dv_p}) : trial[DIV_W-1:0];
        qn[i]  <= {qn_p[DIV_W-2:0], take};
        dv[i]  <= dv_p;
        sd[i]  <= sd_p;
      end
    end
  end

  assign out_vld  = vld[DIV_W-1];
  assign quo      = qn[DIV_W-1];
  assign side_out = sd[DIV_W-1];
endmodule
`default_nettype wire

// File: design/barometric_sensor_compensation_unit.sv
// Channel | direction | handshake           | payload
// input   | in        | in_valid / in_stall  | raw_temp, raw_pressure_bytes
// output  | out       | out_valid / out_stall| temperature_tenths, pressure_pa, div_fault
// config  | in        | wr_en                | wr_index, wr_data
//
// One beat enters per cycle while in_stall is low; a result passes through the two
// 32-stage dividers plus ten register stages before it leaves. Synchronous reset clears
// every valid bit and the coefficient registers. When a result waits under out_stall
// the whole pipeline holds and in_stall rises; nothing is dropped or repeated.
`default_nettype none
module barometric_sensor_compensation_unit import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] raw_temp,
  input  wire logic [23:0] raw_pressure_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] temperature_tenths,
  output logic [19:0]      pressure_pa,
  output logic             div_fault,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [47:0] wr_data
);
  logic [47:0] coef_ac123, coef_ac456;
  logic [31:0] coef_b12, coef_mcmd;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ac123 <= '0;
      coef_ac456 <= '0;
      coef_b12   <= '0;
      coef_mcmd  <= '0;
      oss        <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_AC123: coef_ac123 <= wr_data;
        REG_AC456: coef_ac456 <= wr_data;
        REG_B12:   coef_b12   <= wr_data[31:0];
        REG_MCMD:  coef_mcmd  <= wr_data[31:0];
        REG_OSS:   oss        <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(coef_ac123[47:32]);
  assign ac2 = sx16(coef_ac123[31:16]);
  assign ac3 = sx16(coef_ac123[15:0]);
  assign ac4 = {16'd0, coef_ac456[47:32]};
  assign ac5 = {16'd0, coef_ac456[31:16]};
  assign ac6 = {16'd0, coef_ac456[15:0]};
  assign b1  = sx16(coef_b12[31:16]);
  assign b2  = sx16(coef_b12[15:0]);
  assign mc  = sx16(coef_mcmd[31:16]);
  assign md  = sx16(coef_mcmd[15:0]);

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: raw temperature product and pressure alignment.
  logic        s1_valid;
  logic [31:0] s1_prod;
  logic [23:0] s1_up;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod <= ({16'd0, raw_temp} - ac6) * ac5;
      s1_up   <= raw_pressure_bytes >> (4'd8 - {2'd0, oss});
    end
  end

  // Temperature divider: signs handled outside an unsigned core.
  localparam int unsigned SW1 = 32 + 1 + 1 + 24;
  logic [31:0] d1_x1, d1_d, d1_n, d1_an, d1_ad, d1_q;
  logic        d1_neg, d1_valid;
  logic [SW1-1:0] d1_side;
  assign d1_x1  = asr(s1_prod, 5'd15);
  assign d1_d   = d1_x1 + md;
  assign d1_n   = mc << 11;
  assign d1_neg = d1_n[31] ^ d1_d[31];
  assign d1_an  = d1_n[31] ? (32'd0 - d1_n) : d1_n;
  assign d1_ad  = d1_d[31] ? (32'd0 - d1_d) : d1_d;

  bsc_div #(.SW(SW1)) u_div_t (
    .clk(clk), .rst(rst), .en(adv), .in_vld(s1_valid),
    .num(d1_an), .den(d1_ad),
    .side_in({d1_x1, d1_neg, d1_d == 32'd0, s1_up}),
    .out_vld(d1_valid), .quo(d1_q), .side_out(d1_side)
  );

  // Stage 3: B5.
  logic        s3_valid, s3_fault;
  logic [31:0] s3_b5;
  logic [23:0] s3_up;
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (adv) s3_valid <= d1_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_b5    <= d1_side[57:26] + (d1_side[25] ? (32'd0 - d1_q) : d1_q);
      s3_fault <= d1_side[24];
      s3_up    <= d1_side[23:0];
    end
  end

  // Stage 4: B6 products and the saturated temperature.
  logic [31:0] s4_b6w, s4_tw;
  logic [15:0] s4_tsat;
  assign s4_b6w = s3_b5 - T_OFFSET;
  assign s4_tw  = asr(s3_b5 + T_ROUND, 5'd4);
  always_comb begin
    if ($signed(s4_tw) > 32'sd32767) s4_tsat = 16'h7fff;
    else if ($signed(s4_tw) < -32'sd32768) s4_tsat = 16'h8000;
    else s4_tsat = s4_tw[15:0];
  end

  logic        s4_valid, s4_fault;
  logic [31:0] s4_m1, s4_m2, s4_m3;
  logic [15:0] s4_t;
  logic [23:0] s4_up;
  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (adv) s4_valid <= s3_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_m1    <= s4_b6w * s4_b6w;
      s4_m2    <= ac2 * s4_b6w;
      s4_m3    <= ac3 * s4_b6w;
      s4_t     <= s4_tsat;
      s4_fault <= s3_fault;
      s4_up    <= s3_up;
    end
  end

  // Stage 5: shifts.
  logic        s5_valid, s5_fault;
  logic [31:0] s5_sq, s5_x2a, s5_x1c;
  logic [15:0] s5_t;
  logic [23:0] s5_up;
  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else if (adv) s5_valid <= s4_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sq    <= asr(s4_m1, 5'd12);
      s5_x2a   <= asr(s4_m2, 5'd11);
      s5_x1c   <= asr(s4_m3, 5'd13);
      s5_t     <= s4_t;
      s5_fault <= s4_fault;
      s5_up    <= s4_up;
    end
  end

  // Stage 6: B2 and B1 products.
  logic        s6_valid, s6_fault;
  logic [31:0] s6_m4, s6_m5, s6_x2a, s6_x1c;
  logic [15:0] s6_t;
  logic [23:0] s6_up;
  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else if (adv) s6_valid <= s5_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_m4    <= b2 * s5_sq;
      s6_m5    <= b1 * s5_sq;
      s6_x2a   <= s5_x2a;
      s6_x1c   <= s5_x1c;
      s6_t     <= s5_t;
      s6_fault <= s5_fault;
      s6_up    <= s5_up;
    end
  end

  // Stage 7: B3 and the B4 operand.
  logic [31:0] s7_x3, s7_v, s7_b3w;
  assign s7_x3  = asr(s6_m4, 5'd11) + s6_x2a;
  assign s7_v   = ((ac1 * 32'd4 + s7_x3) << oss) + 32'd2;
  // Signed divide by four rounds toward zero: bias negative values first.
  assign s7_b3w = asr(s7_v + (s7_v[31] ? 32'd3 : 32'd0), 5'd2);

  logic        s7_valid, s7_fault;
  logic [31:0] s7_b3, s7_x3b;
  logic [15:0] s7_t;
  logic [23:0] s7_up;
  always_ff @(posedge clk) begin
    if (rst) s7_valid <= 1'b0;
    else if (adv) s7_valid <= s6_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_b3    <= s7_b3w;
      s7_x3b   <= asr(s6_x1c + asr(s6_m5, 5'd16) + 32'd2, 5'd2);
      s7_t     <= s6_t;
      s7_fault <= s6_fault;
      s7_up    <= s6_up;
    end
  end

  // Stage 8: B4 and B7.
  logic [31:0] s8_b4p;
  assign s8_b4p = ac4 * (s7_x3b + B4_OFFSET);

  logic        s8_valid, s8_fault;
  logic [31:0] s8_b4, s8_b7;
  logic [15:0] s8_t;
  always_ff @(posedge clk) begin
    if (rst) s8_valid <= 1'b0;
    else if (adv) s8_valid <= s7_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_b4    <= s8_b4p >> 15;
      s8_b7    <= ({8'd0, s7_up} - s7_b3) * {16'd0, P_SCALE >> oss};
      s8_t     <= s7_t;
      s8_fault <= s7_fault;
    end
  end

  // Pressure divider.
  localparam int unsigned SW2 = 1 + 1 + 16;
  logic [31:0] d2_q;
  logic        d2_valid;
  logic [SW2-1:0] d2_side;
  bsc_div #(.SW(SW2)) u_div_p (
    .clk(clk), .rst(rst), .en(adv), .in_vld(s8_valid),
    .num(s8_b7[31] ? s8_b7 : {s8_b7[30:0], 1'b0}), .den(s8_b4),
    .side_in({s8_b7[31], s8_fault || (s8_b4 == 32'd0), s8_t}),
    .out_vld(d2_valid), .quo(d2_q), .side_out(d2_side)
  );

  // Stage 9: pressure products.
  logic [31:0] s9_pw, s9_a;
  assign s9_pw = d2_side[17] ? {d2_q[30:0], 1'b0} : d2_q;
  assign s9_a  = asr(s9_pw, 5'd8);

  logic        s9_valid, s9_fault;
  logic [31:0] s9_p, s9_sq, s9_mp;
  logic [15:0] s9_t;
  always_ff @(posedge clk) begin
    if (rst) s9_valid <= 1'b0;
    else if (adv) s9_valid <= d2_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_p     <= s9_pw;
      s9_sq    <= s9_a * s9_a;
      s9_mp    <= P_K2 * s9_pw;
      s9_t     <= d2_side[15:0];
      s9_fault <= d2_side[16];
    end
  end

  // Stage 10: second-order term.
  logic        s10_valid, s10_fault;
  logic [31:0] s10_p, s10_m6, s10_x2;
  logic [15:0] s10_t;
  always_ff @(posedge clk) begin
    if (rst) s10_valid <= 1'b0;
    else if (adv) s10_valid <= s9_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s10_p     <= s9_p;
      s10_m6    <= s9_sq * P_K1;
      s10_x2    <= asr(32'd0 - s9_mp, 5'd16);
      s10_t     <= s9_t;
      s10_fault <= s9_fault;
    end
  end

  // Stage 11: final sum, saturation and the output register.
  logic [31:0] s11_pf;
  logic [19:0] s11_psat;
  assign s11_pf = s10_p + asr(asr(s10_m6, 5'd16) + s10_x2 + P_K3, 5'd4);
  always_comb begin
    if (s11_pf[31]) s11_psat = '0;
    else if (s11_pf > 32'd1048575) s11_psat = 20'hfffff;
    else s11_psat = s11_pf[19:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s10_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      temperature_tenths <= s10_fault ? 16'sd0 : $signed(s10_t);
      pressure_pa        <= s10_fault ? 20'd0 : s11_psat;
      div_fault          <= s10_fault;
    end
  end

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_fault |-> temperature_tenths == 16'sd0 && pressure_pa == 20'd0)
    else $error("fault beat carries non-zero results");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(s10_valid) && $stable(s1_valid))
    else $error("pipeline moved while output was stalled");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    !in_stall && in_valid |=> s1_valid)
    else $error("accepted beat lost at first stage");
endmodule
`default_nettype wire
